// File: sv/rsg_pkg.sv
// Package with shared types, codes and constants of the ramp sweep generator.
package rsg_pkg;

  // Field widths
  localparam int ValueW   = 32;
  localparam int AutoW    = 31;
  localparam int PeriodW  = 24;
  localparam int ElapsedW = 16;
  localparam int ActionW  = 3;
  localparam int ModeW    = 2;
  localparam int TimeW    = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Divider: the dividend is elapsed times auto_step
  localparam int ProdW    = ElapsedW + AutoW;
  localparam int DivSteps = ProdW;
  localparam int DivCntW  = $clog2(DivSteps);

  // Wide signed width for sums, so that nothing wraps
  localparam int WideW = ProdW + 3;

  // Input actions
  typedef enum logic [ActionW-1:0] {
    ActTick  = 3'd0,
    ActPlay  = 3'd1,
    ActPause = 3'd2,
    ActStop  = 3'd3,
    ActBack  = 3'd4,
    ActNext  = 3'd5
  } action_e;

  // Command events reported with each result
  typedef enum logic [ActionW-1:0] {
    EvNone  = 3'd0,
    EvPlay  = 3'd1,
    EvPause = 3'd2,
    EvStop  = 3'd3,
    EvPrev  = 3'd4,
    EvNext  = 3'd5
  } event_e;

  // Sweep modes
  typedef enum logic [ModeW-1:0] {
    ModeOnce     = 2'd0,
    ModeRepeat   = 2'd1,
    ModePingPong = 2'd2
  } sweep_mode_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegRangeStart = 3'd0,
    RegRangeEnd   = 3'd1,
    RegAutoStep   = 3'd2,
    RegManualStep = 3'd3,
    RegStepPeriod = 3'd4,
    RegSmoothMode = 3'd5,
    RegSweepMode  = 3'd6
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [ValueW-1:0]  RangeStartRst = 32'sd0;
  localparam logic [ValueW-1:0]  RangeEndRst   = 32'sd65536;
  localparam logic [AutoW-1:0]   AutoStepRst   = 31'd65536;
  localparam logic [ValueW-1:0]  ManualStepRst = 32'sd65536;
  localparam logic [PeriodW-1:0] StepPeriodRst = 24'd1000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

// File: sv/rsg_in_if.sv
// Handshake channel interfaces for input items and result items.
interface rsg_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [15:0] elapsed;

  modport source (output valid, output action, output elapsed, input ready);
  modport sink   (input valid, input action, input elapsed, output ready);
endinterface

interface rsg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        running;
  logic [2:0]  command_event;
  logic        end_reached;
  logic        auto_paused;

  modport source (output valid, output value, output running, output command_event,
                  output end_reached, output auto_paused, input ready);
  modport sink   (input valid, input value, input running, input command_event,
                  input end_reached, input auto_paused, output ready);
endinterface

// File: sv/rsg_ctrl.sv
// Controller state machine that sequences transfer, division and commit.
module rsg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rsg_pkg::dp_status_t status_i,
  output rsg_pkg::ctrl_cmd_t  cmd_o
);
  import rsg_pkg::*;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StDiv   = 3'b010,
    StApply = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    in_fire      = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_fire     = 1'b1;
          cmd_o.latch = 1'b1;
          state_d     = status_i.need_div ? StDiv : StApply;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StApply;
        end
      end
      StApply: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // The result register is full from commit until its transfer.
  assign out_valid_d = cmd_o.commit | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item always leaves the idle state.
  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != StIdle)
    else $error("accepted item did not start processing");

  // A commit always fills the result register.
  a_commit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not produce a result");

  // The last division step hands over to the commit state.
  a_div_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && status_i.div_last) |=> state_q == StApply)
    else $error("division did not end in the commit state");

endmodule

// File: sv/rsg_dp.sv
// Datapath: configuration, sweep state, serial divider and update logic.
module rsg_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rsg_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic [rsg_pkg::ActionW-1:0]     in_action_i,
  input  logic [rsg_pkg::ElapsedW-1:0]    in_elapsed_i,
  input  rsg_pkg::ctrl_cmd_t              cmd_i,
  output rsg_pkg::dp_status_t             status_o,
  output logic [rsg_pkg::ValueW-1:0]      value_o,
  output logic                            running_o,
  output logic [rsg_pkg::ActionW-1:0]     command_event_o,
  output logic                            end_reached_o,
  output logic                            auto_paused_o
);
  import rsg_pkg::*;

  // Configuration registers
  logic signed [ValueW-1:0] start_q, end_q, manual_q;
  logic [AutoW-1:0]         auto_q;
  logic [PeriodW-1:0]       period_cfg_q;
  logic                     smooth_q;
  logic [ModeW-1:0]         mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= RangeStartRst;
      end_q        <= RangeEndRst;
      auto_q       <= AutoStepRst;
      manual_q     <= ManualStepRst;
      period_cfg_q <= StepPeriodRst;
      smooth_q     <= 1'b0;
      mode_q       <= ModeOnce;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRangeStart: start_q      <= cfg_data_i;
        RegRangeEnd:   end_q        <= cfg_data_i;
        RegAutoStep:   auto_q       <= cfg_data_i[AutoW-1:0];
        RegManualStep: manual_q     <= cfg_data_i;
        RegStepPeriod: period_cfg_q <= cfg_data_i[PeriodW-1:0];
        RegSmoothMode: smooth_q     <= cfg_data_i[0];
        RegSweepMode:  mode_q       <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // A zero period counts as one.
  logic [PeriodW-1:0] period;
  assign period = (period_cfg_q == '0) ? PeriodW'(1) : period_cfg_q;

  // Sweep state
  logic signed [ValueW-1:0] cur_q, cur_d;
  logic                     run_q, run_d;
  logic                     rev_q, rev_d;
  logic [TimeW-1:0]         tss_q, tss_d;

  // Latched input item
  logic [ActionW-1:0]  act_q;
  logic [ElapsedW-1:0] ela_q;

  // Serial restoring divider
  logic [ProdW-1:0]   quo_q, quo_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [PeriodW:0]   rem_sh, rem_sub;
  logic [ProdW-1:0]   prod;

  assign prod   = ProdW'(in_elapsed_i) * ProdW'(auto_q);
  assign rem_sh = {rem_q, quo_q[ProdW-1]};
  assign rem_sub = rem_sh - {1'b0, period};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.latch) begin
      quo_d = prod;
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, period}) begin
        rem_d = rem_sub[PeriodW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[PeriodW-1:0];
        quo_d = {quo_q[ProdW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.latch) begin
      act_q <= in_action_i;
      ela_q <= in_elapsed_i;
    end
  end

  assign status_o.need_div = (in_action_i == ActTick) && run_q && smooth_q;
  assign status_o.div_last = (cnt_q == DivCntW'(DivSteps - 1));

  // Move arithmetic in a wide signed width
  logic signed [WideW-1:0] start_w, end_w, cur_w, inc_w, delta_w, nv_w;
  logic                    fwd, do_move, whole_step;
  logic                    gt_end, lt_end, gt_start, lt_start, out_range;
  logic signed [ValueW-1:0] moved;
  logic                    move_rev, move_stop, move_end;
  logic [TimeW:0]          tss_sum;
  logic [TimeW-1:0]        tss_base;
  logic [ActionW-1:0]      ev;

  assign start_w = WideW'(start_q);
  assign end_w   = WideW'(end_q);
  assign cur_w   = WideW'(cur_q);
  assign fwd     = start_q <= end_q;
  assign whole_step = !smooth_q && (tss_q >= TimeW'(period));

  // Increment and whether a move happens for this action
  always_comb begin
    inc_w   = '0;
    do_move = 1'b0;
    case (act_q)
      ActTick: begin
        do_move = run_q && (smooth_q || whole_step);
        inc_w   = smooth_q ? $signed(WideW'(quo_q)) : $signed(WideW'(auto_q));
      end
      ActBack: begin
        do_move = 1'b1;
        inc_w   = -WideW'(manual_q);
      end
      ActNext: begin
        do_move = 1'b1;
        inc_w   = WideW'(manual_q);
      end
      default: ;
    endcase
  end

  // Apply the increment and the mode rule at the range edges
  assign delta_w  = (fwd == rev_q) ? -inc_w : inc_w;
  assign nv_w     = cur_w + delta_w;
  assign gt_end   = nv_w > end_w;
  assign lt_end   = nv_w < end_w;
  assign gt_start = nv_w > start_w;
  assign lt_start = nv_w < start_w;
  assign out_range = fwd ? (gt_end || lt_start) : (gt_start || lt_end);

  always_comb begin
    moved     = nv_w[ValueW-1:0];
    move_rev  = 1'b0;
    move_stop = 1'b0;
    move_end  = 1'b0;
    if (out_range) begin
      move_end = 1'b1;
      case (mode_q)
        ModeRepeat: begin
          if (fwd) moved = gt_end ? start_q : end_q;
          else     moved = lt_end ? start_q : end_q;
        end
        ModePingPong: begin
          if (fwd) moved = gt_end ? end_q : start_q;
          else     moved = gt_start ? start_q : end_q;
          move_rev = 1'b1;
        end
        default: begin
          if (fwd) moved = gt_end ? end_q : start_q;
          else     moved = lt_end ? end_q : start_q;
          move_stop = 1'b1;
        end
      endcase
    end
  end

  // Saturating time gathering for ticks while running
  assign tss_base = (do_move && !smooth_q) ? '0 : tss_q;
  assign tss_sum  = {1'b0, tss_base} + (TimeW + 1)'(ela_q);

  // Next sweep state per action
  always_comb begin
    cur_d = cur_q;
    run_d = run_q;
    rev_d = rev_q;
    tss_d = tss_q;
    ev    = EvNone;
    if (do_move) begin
      cur_d = moved;
      rev_d = rev_q ^ move_rev;
      if (move_stop) run_d = 1'b0;
    end
    case (act_q)
      ActTick: begin
        if (run_q) begin
          tss_d = tss_sum[TimeW] ? '1 : tss_sum[TimeW-1:0];
        end
      end
      ActPlay: begin
        if (mode_q != ModeRepeat && mode_q != ModePingPong) begin
          if (fwd ? (cur_q >= end_q) : (cur_q <= end_q)) cur_d = start_q;
        end
        run_d = 1'b1;
        ev    = EvPlay;
      end
      ActPause: begin
        run_d = 1'b0;
        ev    = EvPause;
      end
      ActStop: begin
        run_d = 1'b0;
        cur_d = start_q;
        ev    = EvStop;
      end
      ActBack: ev = EvPrev;
      ActNext: ev = EvNext;
      default: ;
    endcase
  end

  // Sweep state is written at commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
      run_q <= 1'b0;
      rev_q <= 1'b0;
      tss_q <= '0;
    end else if (cmd_i.commit) begin
      cur_q <= cur_d;
      run_q <= run_d;
      rev_q <= rev_d;
      tss_q <= tss_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      value_o         <= cur_d;
      running_o       <= run_d;
      command_event_o <= ev;
      end_reached_o   <= do_move && move_end;
      auto_paused_o   <= do_move && move_stop;
    end
  end

endmodule

// File: sv/ramp_sweep_generator.sv
// Top level of the ramp sweep generator: controller, datapath and channel hookup.
//
// Input channel in_i carries one item per transfer: an action (tick, play,
// pause, stop, step back, step next) and the elapsed time of a tick. Output
// channel out_o returns exactly one result per item: the sweep value in
// signed Q16.16, the running flag, the executed command, and the end and
// auto-pause flags. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while no item is
// in flight, as the block itself does not enforce this. A smooth tick while
// running is captured together with elapsed * auto_step, then passes the
// serial restoring divider (one quotient bit per cycle) and a commit step;
// every other item goes straight from capture to commit. One item is
// processed at a time; the next one is accepted in the cycle after commit.
// The result sits in an output register, so a new item is taken while a
// result still waits; if the receiver stalls, the following item waits in
// the commit step until the register is free, and input ready stays low.
// Reset clears the sweep value, the running and direction flags and the
// gathered time, and loads the register reset values.
module ramp_sweep_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rsg_in_if.sink                        in_i,
  rsg_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [rsg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rsg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rsg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing
  rsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  rsg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_action_i     (in_i.action),
    .in_elapsed_i    (in_i.elapsed),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_o         (out_o.value),
    .running_o       (out_o.running),
    .command_event_o (out_o.command_event),
    .end_reached_o   (out_o.end_reached),
    .auto_paused_o   (out_o.auto_paused)
  );

endmodule
